>>> src/palette_sprite_blitter_top_defines.svh
// ---------------------------------------------------------------------------
// Palette sprite blitter assertion macros
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PALETTE_SPRITE_BLITTER_TOP_DEFINES_SVH
`define PALETTE_SPRITE_BLITTER_TOP_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define PSB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define PSB_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psb_pkg.sv
// ---------------------------------------------------------------------------
// Palette sprite blitter package
// Field widths, request codes and packed payload types.
// ---------------------------------------------------------------------------
package psb_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_PAL   = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [3:0]         pad;
    logic [DIM_W-1:0]   data_byte;
    logic [DIM_W-1:0]   pixel_scale;
    logic [DIM_W-1:0]   sprite_h;
    logic [DIM_W-1:0]   sprite_w;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] origin_x;
    logic [COLOR_W-1:0] pal_color;
    logic [NIB_W-1:0]   pal_index;
  } in_data_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x0;
  } rect_t;

  typedef struct packed {
    logic             act;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } pos_t;

endpackage

>>> src/palette_sprite_blitter_top.sv
// A byte's first rectangle passes the palette read stage, the b_rect stage and
// the output register; a second follows in the next cycle unless back-pressure
// holds it. A request is accepted every cycle unless the a stage is full and
// back-pressure or a byte with two drawn pixels holds the b_rect stage.
// Reset clears the sprite walk, sets the scale to one and the transparent
// color to zero; palette entries hold no value until written.
// ---------------------------------------------------------------------------
// Palette sprite blitter
// Walks 4-bit paletted sprite pixels and issues scaled fill rectangles.
// ---------------------------------------------------------------------------
module palette_sprite_blitter_top #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psb_pkg::COLOR_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // pal_index, pal_color, origin_x, origin_y, sprite_w, sprite_h,
  // pixel_scale, data_byte, zero fill
  input  logic [psb_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // cmd
  input  logic [psb_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // rect_x0, rect_y0, rect_x1, rect_y1, rect_color
  output logic [psb_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import psb_pkg::*;

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [NIB_W:0] NUM_ENT = (NIB_W + 1)'(PALETTE_ENTRIES);

  function automatic pos_t step_pos(pos_t p, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    pos_t n;
    n = p;
    if (p.act) begin
      n.row = p.row + 8'd1;
      if (n.row >= h) begin
        n.row = '0;
        n.col = p.col + 8'd1;
        if (n.col >= w) begin
          n.act = 1'b0;
        end
      end
    end
    return n;
  endfunction

  function automatic rect_t make_rect(logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                                      logic [DIM_W-1:0] c, logic [DIM_W-1:0] r,
                                      logic [DIM_W-1:0] s, logic [COLOR_W-1:0] color);
    rect_t              rc;
    logic [COORD_W-1:0] s16;
    s16      = {8'd0, s};
    rc.x0    = bx + ({8'd0, c} * s16);
    rc.y0    = by + ({8'd0, r} * s16);
    rc.x1    = rc.x0 + s16 - 16'd1;
    rc.y1    = rc.y0 + s16 - 16'd1;
    rc.color = color;
    return rc;
  endfunction

  in_data_t           in_d;
  cmd_e               cmd;
  logic               in_acc;
  logic               data_acc;

  logic [COLOR_W-1:0] transp_q, transp_d;
  pos_t               pos_q, pos_d;
  logic [COORD_W-1:0] base_x_q, base_x_d;
  logic [COORD_W-1:0] base_y_q, base_y_d;
  logic [DIM_W-1:0]   scale_q, scale_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;

  pos_t               p1, p2;
  logic [NIB_W-1:0]   nib [2];
  logic [1:0]         in_rng;
  logic [1:0]         cand;
  logic [IDX_W-1:0]   raddr [2];
  logic               pal_we;
  logic [COLOR_W-1:0] rd_color [2];

  logic [1:0]         a_pend_q, a_pend_d;
  logic [DIM_W-1:0]   a_col_q [2];
  logic [DIM_W-1:0]   a_row_q [2];
  logic [COORD_W-1:0] a_base_x_q;
  logic [COORD_W-1:0] a_base_y_q;
  logic [DIM_W-1:0]   a_scale_q;

  logic [1:0]         b_pend_q, b_pend_d;
  rect_t              b_rect_q [2];
  logic [1:0]         drawn;

  logic               m_valid_q, m_valid_d;
  rect_t              out_rect_q;
  logic               out_last_q;

  logic               out_free, b_single, b_free, a_free, out_load;

  assign in_d = in_data_t'(s_axis_tdata_i);
  assign cmd  = cmd_e'(s_axis_tuser_i);

  assign nib[0]    = in_d.data_byte[7:4];
  assign nib[1]    = in_d.data_byte[3:0];
  assign in_rng[0] = {1'b0, nib[0]} < NUM_ENT;
  assign in_rng[1] = {1'b0, nib[1]} < NUM_ENT;
  assign p1        = step_pos(pos_q, width_q, height_q);
  assign p2        = step_pos(p1, width_q, height_q);
  assign cand[0]   = pos_q.act && in_rng[0];
  assign cand[1]   = p1.act && in_rng[1];
  assign raddr[0]  = in_rng[0] ? nib[0][IDX_W-1:0] : '0;
  assign raddr[1]  = in_rng[1] ? nib[1][IDX_W-1:0] : '0;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign b_single = b_pend_q[0] ^ b_pend_q[1];
  assign b_free   = (b_pend_q == 2'b00) || (out_free && b_single);
  assign a_free   = (a_pend_q == 2'b00) || b_free;
  assign out_load = out_free && (b_pend_q != 2'b00);
  assign in_acc   = s_axis_tvalid_i && a_free;
  assign data_acc = in_acc && (cmd == CMD_DATA);
  assign pal_we   = in_acc && (cmd == CMD_PAL) && ({1'b0, in_d.pal_index} < NUM_ENT);

  assign drawn[0] = a_pend_q[0] && (rd_color[0] != transp_q);
  assign drawn[1] = a_pend_q[1] && (rd_color[1] != transp_q);

  psb_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i    (clk_i),
    .we_i     (pal_we),
    .waddr_i  (in_d.pal_index[IDX_W-1:0]),
    .wdata_i  (in_d.pal_color),
    .re_i     (data_acc),
    .raddr0_i (raddr[0]),
    .raddr1_i (raddr[1]),
    .rdata0_o (rd_color[0]),
    .rdata1_o (rd_color[1])
  );

  always_comb begin
    transp_d = cfg_we_i ? cfg_wdata_i : transp_q;
    pos_d    = pos_q;
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    scale_d  = scale_q;
    width_d  = width_q;
    height_d = height_q;
    if (in_acc) begin
      unique case (cmd)
        CMD_START: begin
          base_x_d  = in_d.origin_x;
          base_y_d  = in_d.origin_y;
          width_d   = in_d.sprite_w;
          height_d  = in_d.sprite_h;
          scale_d   = in_d.pixel_scale;
          pos_d.col = '0;
          pos_d.row = '0;
          pos_d.act = (in_d.sprite_w != '0) && (in_d.sprite_h != '0);
        end
        CMD_DATA: begin
          pos_d = p2;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    a_pend_d = a_pend_q;
    if (a_free) begin
      a_pend_d = data_acc ? cand : 2'b00;
    end
    b_pend_d = b_pend_q;
    if (b_free) begin
      b_pend_d = drawn;
    end else if (out_free) begin
      b_pend_d = 2'b10;
    end
    m_valid_d = m_valid_q;
    if (out_free) begin
      m_valid_d = (b_pend_q != 2'b00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_q  <= '0;
      pos_q     <= '0;
      base_x_q  <= '0;
      base_y_q  <= '0;
      scale_q   <= 8'd1;
      width_q   <= '0;
      height_q  <= '0;
      a_pend_q  <= '0;
      b_pend_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      transp_q  <= transp_d;
      pos_q     <= pos_d;
      base_x_q  <= base_x_d;
      base_y_q  <= base_y_d;
      scale_q   <= scale_d;
      width_q   <= width_d;
      height_q  <= height_d;
      a_pend_q  <= a_pend_d;
      b_pend_q  <= b_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      a_col_q[0] <= pos_q.col;
      a_row_q[0] <= pos_q.row;
      a_col_q[1] <= p1.col;
      a_row_q[1] <= p1.row;
      a_base_x_q <= base_x_q;
      a_base_y_q <= base_y_q;
      a_scale_q  <= scale_q;
    end
    if (b_free) begin
      b_rect_q[0] <= make_rect(a_base_x_q, a_base_y_q, a_col_q[0], a_row_q[0],
                               a_scale_q, rd_color[0]);
      b_rect_q[1] <= make_rect(a_base_x_q, a_base_y_q, a_col_q[1], a_row_q[1],
                               a_scale_q, rd_color[1]);
    end
    if (out_load) begin
      out_rect_q <= b_pend_q[0] ? b_rect_q[0] : b_rect_q[1];
      out_last_q <= b_single;
    end
  end

  assign s_axis_tready_o = a_free;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_rect_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> src/psb_palette.sv
// ---------------------------------------------------------------------------
// Palette memory
// One write port and two registered read ports for the two pixels of a byte.
// ---------------------------------------------------------------------------
module psb_palette #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(ENTRIES)-1:0]        waddr_i,
  input  logic [psb_pkg::COLOR_W-1:0]       wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(ENTRIES)-1:0]        raddr0_i,
  input  logic [$clog2(ENTRIES)-1:0]        raddr1_i,
  output logic [psb_pkg::COLOR_W-1:0]       rdata0_o,
  output logic [psb_pkg::COLOR_W-1:0]       rdata1_o
);
  import psb_pkg::*;

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [COLOR_W-1:0] rdata0_q;
  logic [COLOR_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> src/psb_checker.sv
// ---------------------------------------------------------------------------
// Palette sprite blitter checker
// Port-level properties of the rectangle stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "palette_sprite_blitter_top_defines.svh"

module psb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [psb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);
  import psb_pkg::*;

  rect_t              rc;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;

  assign rc = rect_t'(m_axis_tdata_o);
  assign dx = rc.x1 - rc.x0;
  assign dy = rc.y1 - rc.y0;

  `PSB_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
    "Stalled rectangle changed or dropped")
  `PSB_ASSERT_NEXT(a_pair_follows, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o,
    m_axis_tvalid_o, "Second rectangle of a byte did not follow")
  `PSB_ASSERT_ALWAYS(a_square, !m_axis_tvalid_o || (dx == dy),
    "Rectangle is not square")
  `PSB_ASSERT_ALWAYS(a_extent, !m_axis_tvalid_o || (dx < 16'd255) || (dx == 16'hFFFF),
    "Rectangle extent exceeds the largest scale")

endmodule

bind palette_sprite_blitter_top psb_checker u_psb_checker (.*);
